[hdl/printable_utf8_validator_macros.svh]
// Assertion macros for the printable UTF-8 validator.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PRINTABLE_UTF8_VALIDATOR_MACROS_SVH
`define PRINTABLE_UTF8_VALIDATOR_MACROS_SVH

// Implication checked at every rising clock edge, off during reset
`define PUV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Plain condition that must hold at every edge outside reset
`define PUV_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

[hdl/puv_pkg.sv]
// Package for the printable UTF-8 validator: decoder state type, code point
// limits and the printable / well-formed checks. No dependencies.
`default_nettype none

package puv_pkg;

	localparam int CP_W = 21;

	typedef logic [CP_W-1:0] cp_t;

	// Decoder state carried between bytes of one string
	typedef struct packed {
		logic [1:0] pending;
		logic [1:0] seq_len;
		cp_t        cp;
		logic       failed;
	} dec_state_t;

	localparam dec_state_t DEC_CLEAR = '{pending: 2'd0, seq_len: 2'd0, cp: '0, failed: 1'b0};

	// Code point limits
	localparam cp_t CP_C0_END     = 21'h00001F;
	localparam cp_t CP_DEL        = 21'h00007F;
	localparam cp_t CP_C1_BEGIN   = 21'h000080;
	localparam cp_t CP_C1_END     = 21'h00009F;
	localparam cp_t CP_TWO_MIN    = 21'h000080;
	localparam cp_t CP_THREE_MIN  = 21'h000800;
	localparam cp_t CP_FOUR_MIN   = 21'h010000;
	localparam cp_t CP_SURR_BEGIN = 21'h00D800;
	localparam cp_t CP_SURR_END   = 21'h00DFFF;
	localparam cp_t CP_PUA_BEGIN  = 21'h00E000;
	localparam cp_t CP_PUA_END    = 21'h00F8FF;
	localparam cp_t CP_NC_FFFE    = 21'h00FFFE;
	localparam cp_t CP_NC_FFFF    = 21'h00FFFF;
	localparam cp_t CP_SPUA_BEGIN = 21'h0F0000;
	localparam cp_t CP_SPUA_END   = 21'h0FFFFD;
	localparam cp_t CP_SPUB_BEGIN = 21'h100000;
	localparam cp_t CP_SPUB_END   = 21'h10FFFD;
	localparam cp_t CP_MAX        = 21'h10FFFF;

	// Continuation counts per sequence length
	localparam logic [1:0] CONT_ONE   = 2'd1;
	localparam logic [1:0] CONT_TWO   = 2'd2;
	localparam logic [1:0] CONT_THREE = 2'd3;

	function automatic logic cp_printable(cp_t cp);
		logic ok;
		ok = 1'b1;
		if (cp <= CP_C0_END || cp == CP_DEL) ok = 1'b0;
		if (cp >= CP_C1_BEGIN && cp <= CP_C1_END) ok = 1'b0;
		if (cp >= CP_SURR_BEGIN && cp <= CP_SURR_END) ok = 1'b0;
		if (cp >= CP_PUA_BEGIN && cp <= CP_PUA_END) ok = 1'b0;
		if (cp >= CP_SPUA_BEGIN && cp <= CP_SPUA_END) ok = 1'b0;
		if (cp >= CP_SPUB_BEGIN && cp <= CP_SPUB_END) ok = 1'b0;
		if (cp == CP_NC_FFFE || cp == CP_NC_FFFF) ok = 1'b0;
		return ok;
	endfunction

	// Rejects overlong forms and anything past the last code point
	function automatic logic cp_well_formed(cp_t cp, logic [1:0] conts);
		logic ok;
		unique case (conts)
			CONT_ONE: ok = (cp >= CP_TWO_MIN);
			CONT_TWO: ok = (cp >= CP_THREE_MIN);
			default:  ok = (cp >= CP_FOUR_MIN) && (cp <= CP_MAX);
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

[hdl/puv_step.sv]
// One decode step of the printable UTF-8 validator: next decoder state
// from the current state and one byte. Depends on puv_pkg.
`default_nettype none

module puv_step
	import puv_pkg::*;
(
	input  wire  dec_state_t cur,
	input  wire  logic [7:0] data_byte,
	output dec_state_t       nxt
);

	logic [1:0] pending_dec;
	cp_t        cp_shift;

	assign pending_dec = cur.pending - 2'd1;
	assign cp_shift    = {cur.cp[CP_W-7:0], data_byte[5:0]};

	// Lead byte decode or continuation merge
	always_comb begin
		nxt = cur;
		if (cur.pending == 2'd0) begin
			priority if (!data_byte[7]) begin
				if (!cp_printable({{(CP_W-8){1'b0}}, data_byte})) nxt.failed = 1'b1;
			end else if (data_byte[7:5] == 3'b110) begin
				nxt.cp      = {{(CP_W-5){1'b0}}, data_byte[4:0]};
				nxt.pending = CONT_ONE;
				nxt.seq_len = CONT_ONE;
			end else if (data_byte[7:4] == 4'b1110) begin
				nxt.cp      = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				nxt.pending = CONT_TWO;
				nxt.seq_len = CONT_TWO;
			end else if (data_byte[7:3] == 5'b11110) begin
				nxt.cp      = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				nxt.pending = CONT_THREE;
				nxt.seq_len = CONT_THREE;
			end else begin
				nxt.failed = 1'b1;
			end
		end else if (data_byte[7:6] != 2'b10) begin
			// broken sequence is dropped; this byte is not reread as a lead
			nxt.failed  = 1'b1;
			nxt.pending = 2'd0;
		end else begin
			nxt.cp      = cp_shift;
			nxt.pending = pending_dec;
			if (pending_dec == 2'd0) begin
				if (!cp_well_formed(cp_shift, cur.seq_len) || !cp_printable(cp_shift))
					nxt.failed = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/printable_utf8_validator.sv]
// Printable UTF-8 validator top level: input register, decode stage and
// verdict register. Depends on puv_pkg, puv_step and the assertion macros.
// Throughput: one byte per cycle, set by the single decode step per byte, unless a last
// byte waits in the input register for a full verdict slot. The verdict passes the
// input register, then the verdict register; other bytes give no item.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// decoder state; a verdict also clears the state for the next string.
`default_nettype none
`include "printable_utf8_validator_macros.svh"

module printable_utf8_validator
	import puv_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] data_byte
	input  wire        s_tlast,   // last_byte
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata    // [0] printable, [7:1] zero
);

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;
	dec_state_t st_q;
	dec_state_t st_next;
	logic       out_valid_q;
	logic       out_print_q;
	logic       out_free;
	logic       s1_fire;

	// Stage 1 advances unless it holds a last byte and the verdict slot is full and not being taken
	assign out_free = !out_valid_q || m_tready;
	assign s1_fire  = in_valid_s1 && (!in_last_s1 || out_free);
	assign s_tready = !in_valid_s1 || s1_fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	puv_step u_step (
		.cur       (st_q),
		.data_byte (in_byte_s1),
		.nxt       (st_next)
	);

	// Decoder state, cleared after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DEC_CLEAR;
		end else if (s1_fire) begin
			st_q <= in_last_s1 ? DEC_CLEAR : st_next;
		end
	end

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_print_q <= 1'b0;
		end else begin
			if (s1_fire && in_last_s1) begin
				out_valid_q <= 1'b1;
				out_print_q <= !st_next.failed && (st_next.pending == 2'd0);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_print_q};

	// Checks
	`PUV_ASSERT(a_verdict_issued, s1_fire && in_last_s1 |=> m_tvalid, "last byte gave no verdict")
	`PUV_ASSERT(a_state_cleared, s1_fire && in_last_s1 |=> st_q == DEC_CLEAR, "state not cleared")
	`PUV_ALWAYS(a_pending_bound, st_q.pending <= st_q.seq_len, "pending exceeds sequence length")

endmodule

`default_nettype wire
